@@ rtl/dbmh_pkg.sv @@
`timescale 1ns / 1ps

package dbmh_pkg;

  localparam int MAX_BINS_DEF = 64;

  localparam int SUM_W   = 48;
  localparam int HIT_W   = 32;
  localparam int MEAN_W  = 17;
  localparam int POS_W   = 32;
  localparam int STEP_W  = 6;

  localparam logic [MEAN_W-1:0] ONE_Q16 = 17'h10000;

  localparam logic REQ_ADD  = 1'b0;
  localparam logic REQ_READ = 1'b1;

  localparam logic REG_BIN_WIDTH = 1'b0;
  localparam logic REG_BIN_COUNT = 1'b1;

  localparam logic [STEP_W-1:0] DIST_STEPS = 6'd32;
  localparam logic [STEP_W-1:0] MEAN_STEPS = 6'd48;

  localparam logic [31:0] BIN_WIDTH_RST = 32'd1000;
  localparam logic [6:0]  BIN_COUNT_RST = 7'd64;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
    logic [SUM_W-1:0]  dividend;
    logic [HIT_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] quotient;
  } div_rsp_t;

endpackage

@@ rtl/distance_binned_mean_histogram.sv @@
`timescale 1ns / 1ps

// Channel  Direction  Handshake          Payload
// cfg      in         cfg_we             cfg_index, cfg_wdata
// in       in         in_valid/in_stall  req_type, contig_*, pos_*, score, read_bin
// out      out        out_valid/out_stall bin_sum, bin_hits, bin_mean
//
// An add beat that counts runs the 32 steps of the shared radix-2 divider, then a store
// read and a store write; an add beat that does not count leaves the block idle.
// A read beat in range reads the store, then runs the 48 divider steps of the mean.
// After reset the store clears all MAX_BINS bins one bin per cycle, with in_stall high.
// A finished read result waits in the output register while the next beat is taken.

module distance_binned_mean_histogram
  import dbmh_pkg::*;
#(
  parameter int MAX_BINS = MAX_BINS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               req_type,
  input  logic [15:0]        contig_first,
  input  logic [15:0]        contig_second,
  input  logic [POS_W-1:0]   pos_first,
  input  logic [POS_W-1:0]   pos_second,
  input  logic [16:0]        score,
  input  logic [5:0]         read_bin,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [SUM_W-1:0]   bin_sum,
  output logic [HIT_W-1:0]   bin_hits,
  output logic [MEAN_W-1:0]  bin_mean
);

  localparam int IDX_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_BINS - 1);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b00000001,
    S_ADIV   = 8'b00000010,
    S_AREQ   = 8'b00000100,
    S_AWR    = 8'b00001000,
    S_RREQ   = 8'b00010000,
    S_RSTART = 8'b00100000,
    S_RDIV   = 8'b01000000,
    S_DONE   = 8'b10000000
  } state_t;

  state_t state;
  state_t state_next;

  logic [31:0]       bin_width;
  logic [6:0]        bin_count;
  logic [IDX_W-1:0]  addr;
  logic [16:0]       sc;
  logic [SUM_W-1:0]  res_sum;
  logic [HIT_W-1:0]  res_hits;
  logic [MEAN_W-1:0] res_mean;

  div_req_t          div_req;
  div_rsp_t          div_rsp;
  logic              st_we;
  logic [SUM_W-1:0]  st_wsum;
  logic [HIT_W-1:0]  st_whits;
  logic [SUM_W-1:0]  st_rsum;
  logic [HIT_W-1:0]  st_rhits;
  logic              clearing;

  logic              accept;
  logic              counts;
  logic              rb_out;
  logic [IDX_W-1:0]  last_bin;
  logic [IDX_W-1:0]  q_bin;
  logic [SUM_W:0]    sum_add;
  logic [MEAN_W-1:0] mean_sat;
  logic              out_load;

  dbmh_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  dbmh_store #(
    .MAX_BINS (MAX_BINS),
    .IDX_W    (IDX_W)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .we       (st_we),
    .waddr    (addr),
    .wsum     (st_wsum),
    .whits    (st_whits),
    .raddr    (addr),
    .rsum     (st_rsum),
    .rhits    (st_rhits),
    .clearing (clearing)
  );

  assign in_stall = (state != S_IDLE) || clearing;
  assign accept   = in_valid && !in_stall;
  assign counts   = (contig_first == contig_second) && (pos_first < pos_second);
  assign rb_out   = {26'd0, read_bin} >= 32'(MAX_BINS);
  assign out_load = (state == S_DONE) && (!out_valid || !out_stall);

  always_comb begin
    if (bin_count == 7'd0) begin
      last_bin = '0;
    end else if (32'(bin_count) > 32'(MAX_BINS)) begin
      last_bin = LAST_IDX;
    end else begin
      last_bin = IDX_W'(bin_count - 7'd1);
    end
    if (div_rsp.quotient[31:0] > 32'(last_bin)) begin
      q_bin = last_bin;
    end else begin
      q_bin = IDX_W'(div_rsp.quotient[31:0]);
    end
    if (div_rsp.quotient > SUM_W'(ONE_Q16)) begin
      mean_sat = ONE_Q16;
    end else begin
      mean_sat = div_rsp.quotient[MEAN_W-1:0];
    end
  end

  always_comb begin
    sum_add  = {1'b0, st_rsum} + (SUM_W + 1)'(sc);
    st_we    = (state == S_AWR);
    st_wsum  = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
    st_whits = (&st_rhits) ? st_rhits : st_rhits + 1'b1;
  end

  always_comb begin
    div_req = '0;
    if (accept && req_type == REQ_ADD && counts) begin
      div_req.start    = 1'b1;
      div_req.steps    = DIST_STEPS;
      div_req.dividend = {pos_second - pos_first, 16'h0000};
      div_req.divisor  = bin_width;
    end else if (state == S_RSTART) begin
      div_req.start    = 1'b1;
      div_req.steps    = MEAN_STEPS;
      div_req.dividend = st_rsum;
      div_req.divisor  = (st_rhits == '0) ? 32'd1 : st_rhits;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (req_type == REQ_ADD) begin
            state_next = counts ? S_ADIV : S_IDLE;
          end else begin
            state_next = rb_out ? S_DONE : S_RREQ;
          end
        end
      end
      S_ADIV: begin
        if (div_rsp.done) begin
          state_next = S_AREQ;
        end
      end
      S_AREQ:   state_next = S_AWR;
      S_AWR:    state_next = S_IDLE;
      S_RREQ:   state_next = S_RSTART;
      S_RSTART: state_next = S_RDIV;
      S_RDIV: begin
        if (div_rsp.done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      bin_width <= BIN_WIDTH_RST;
      bin_count <= BIN_COUNT_RST;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_BIN_WIDTH: bin_width <= cfg_wdata;
          REG_BIN_COUNT: bin_count <= cfg_wdata[6:0];
          default:       bin_width <= bin_width;
        endcase
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sc   <= (score > ONE_Q16) ? ONE_Q16 : score;
      addr <= IDX_W'(read_bin);
      if (req_type == REQ_READ && rb_out) begin
        res_sum  <= '0;
        res_hits <= '0;
        res_mean <= '0;
      end
    end
    if (state == S_ADIV && div_rsp.done) begin
      addr <= q_bin;
    end
    if (state == S_RSTART) begin
      res_sum  <= st_rsum;
      res_hits <= st_rhits;
    end
    if (state == S_RDIV && div_rsp.done) begin
      res_mean <= mean_sat;
    end
    if (out_load) begin
      bin_sum  <= res_sum;
      bin_hits <= res_hits;
      bin_mean <= res_mean;
    end
  end

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result appeared outside the finish state");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == S_ADIV || state == S_RDIV))
    else $error("divider finished while no division was pending");

  a_no_write_clear: assert property (@(posedge clk) disable iff (rst)
    st_we |-> !clearing)
    else $error("store write during clearing pass");

  a_mean_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (bin_mean <= ONE_Q16))
    else $error("mean above one");

endmodule

@@ rtl/dbmh_div.sv @@
`timescale 1ns / 1ps

module dbmh_div
  import dbmh_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] cnt;
  logic [HIT_W-1:0]  rem;
  logic [SUM_W-1:0]  dq;
  logic [HIT_W-1:0]  dvs;

  logic [HIT_W:0]    sh;
  logic [HIT_W+1:0]  diff;

  always_comb begin
    sh   = {rem, dq[SUM_W-1]};
    diff = {1'b0, sh} - {2'b00, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.steps;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      dq  <= req.dividend;
      dvs <= req.divisor;
    end else if (busy) begin
      if (!diff[HIT_W+1]) begin
        rem <= diff[HIT_W-1:0];
      end else begin
        rem <= sh[HIT_W-1:0];
      end
      dq <= {dq[SUM_W-2:0], ~diff[HIT_W+1]};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = dq;

endmodule

@@ rtl/dbmh_store.sv @@
`timescale 1ns / 1ps

module dbmh_store
  import dbmh_pkg::*;
#(
  parameter int MAX_BINS = MAX_BINS_DEF,
  parameter int IDX_W    = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  logic [SUM_W-1:0] wsum,
  input  logic [HIT_W-1:0] whits,
  input  logic [IDX_W-1:0] raddr,
  output logic [SUM_W-1:0] rsum,
  output logic [HIT_W-1:0] rhits,
  output logic             clearing
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_BINS - 1);

  logic [SUM_W-1:0] sum_mem [MAX_BINS];
  logic [HIT_W-1:0] hit_mem [MAX_BINS];
  logic [IDX_W-1:0] clr_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      clr_idx <= clr_idx + 1'b1;
      if (clr_idx == LAST_IDX) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      sum_mem[clr_idx] <= '0;
      hit_mem[clr_idx] <= '0;
    end else if (we) begin
      sum_mem[waddr] <= wsum;
      hit_mem[waddr] <= whits;
    end
  end

  always_ff @(posedge clk) begin
    rsum  <= sum_mem[raddr];
    rhits <= hit_mem[raddr];
  end

endmodule
